/* hdl/mower_obstacle_motion_fsm_unit_macros.svh */
// ----------------------------------------------------------------------------
// Mower obstacle motion FSM - assertion macros
// Shared concurrent assertion helpers for the motion controller.
// ----------------------------------------------------------------------------
`ifndef MOWER_OBSTACLE_MOTION_FSM_UNIT_MACROS_SVH
`define MOWER_OBSTACLE_MOTION_FSM_UNIT_MACROS_SVH

// checked property, disabled while reset is held
`define MOFSM_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("mofsm assertion failed");

// checked property, also during reset
`define MOFSM_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("mofsm assertion failed");

`endif

/* hdl/mofsm_pkg.sv */
// ----------------------------------------------------------------------------
// Mower obstacle motion FSM - package
// Shared widths and constants for heading conversion and the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mofsm_pkg;

  localparam int unsigned MDEG_W  = 19;
  localparam int unsigned DEG_W   = 9;
  localparam int unsigned QDEG_W  = 10;

  // ceil(2^29 / 1000), exact quotient for any 19 bit operand
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned RECIP_SHIFT = 29;
  localparam logic [RECIP_W-1:0] RECIP_1000 = RECIP_W'(536871);
  localparam int unsigned PROD_W = MDEG_W + RECIP_W;

  localparam logic [QDEG_W-1:0] FULL_TURN_DEG = QDEG_W'(360);
  localparam logic [DEG_W-1:0]  HALF_TURN_DEG = DEG_W'(180);
  localparam logic [DEG_W-1:0]  TURN_DEG      = DEG_W'(45);

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_FAST_SPEED     = 3'd0,
    REG_SLOW_SPEED     = 3'd1,
    REG_BLADE_SPEED    = 3'd2,
    REG_SLOW_DISTANCE  = 3'd3,
    REG_TURN_DISTANCE  = 3'd4,
    REG_CLOSE_DISTANCE = 3'd5,
    REG_REVERSE_TICKS  = 3'd6,
    REG_ROTATE_TICKS   = 3'd7
  } reg_idx_e;

endpackage

`default_nettype wire

/* hdl/mower_obstacle_motion_fsm_unit.sv */
// ----------------------------------------------------------------------------
// Mower obstacle motion FSM - top level
// Drive mode machine stepping once per control tick request.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   s_axis_tdata[39:0]
//  m_axis    out  m_axis_tvalid/m_axis_tready   m_axis_tdata[47:0]
//  cfg       in   cfg_we_i                      cfg_idx_i, cfg_data_i
//
//  One request per cycle unless m_axis stalls; registered through the input register,
//  heading register with the reciprocal multiply, and mode/result register.
//  Reset clears the mode machine, held outputs and counters; no clearing pass.
//  A stalled result freezes the whole pipe; s_axis_tready drops with it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "mower_obstacle_motion_fsm_unit_macros.svh"

module mower_obstacle_motion_fsm_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // [0] bumper_a, [1] bumper_b, [2] lift_ok, [18:3] distance_mm,
  // [37:19] heading_mdeg, [39:38] zero
  input  wire logic [39:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // [3:0] mode, [15:4] left_speed, [16] left_dir, [28:17] right_speed,
  // [29] right_dir, [41:30] blade_out, [42] drives_disabled, [47:43] zero
  output logic      [47:0] m_axis_tdata,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [15:0] cfg_data_i
);

  typedef enum logic [3:0] {
    MODE_INIT     = 4'd0,
    MODE_FWD      = 4'd1,
    MODE_SLOW     = 4'd2,
    MODE_BACK     = 4'd3,
    MODE_STARTROT = 4'd4,
    MODE_ROT      = 4'd5,
    MODE_STOP     = 4'd6,
    MODE_CHECK    = 4'd7,
    MODE_ERROR    = 4'd8
  } mode_e;

  localparam logic [2:0] NEAR_LIMIT = 3'd5;
  localparam logic [1:0] HALT_LIMIT = 2'd2;
  localparam logic [1:0] HALT_MAX   = 2'd3;

  // configuration
  logic [11:0] fast_speed_q, slow_speed_q, blade_speed_q;
  logic [15:0] slow_dist_q, turn_dist_q, close_dist_q;
  logic [7:0]  rev_ticks_q, rot_ticks_q;

  // pipeline
  logic        adv;
  logic        s1_valid_q, s2_valid_q, out_valid_q;
  logic        s1_hit_q, s1_lift_q, s2_hit_q, s2_lift_q;
  logic [15:0] s1_dist_q, s2_dist_q;
  logic [mofsm_pkg::MDEG_W-1:0] s1_mdeg_q;
  logic [mofsm_pkg::DEG_W-1:0]  s1_deg, s2_deg_q;

  // machine state
  mode_e       mode_q, mode_d;
  logic [11:0] left_q, left_d, right_q, right_d, blade_q, blade_d;
  logic        ldir_q, ldir_d, rdir_q, rdir_d;
  logic [7:0]  rev_cnt_q, rev_cnt_d, rot_cnt_q, rot_cnt_d;
  logic [1:0]  halt_cnt_q, halt_cnt_d;
  logic [2:0]  near_cnt_q, near_cnt_d;
  logic        bump_q, bump_d;
  logic [mofsm_pkg::DEG_W-1:0] start_hdg_q, start_hdg_d;
  logic        off_d, off_q;

  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fast_speed_q  <= 12'd2000;
      slow_speed_q  <= 12'd1000;
      blade_speed_q <= 12'd4000;
      slow_dist_q   <= 16'd1000;
      turn_dist_q   <= 16'd800;
      close_dist_q  <= 16'd400;
      rev_ticks_q   <= 8'd10;
      rot_ticks_q   <= 8'd10;
    end else if (cfg_we_i) begin
      case (mofsm_pkg::reg_idx_e'(cfg_idx_i))
        mofsm_pkg::REG_FAST_SPEED:     fast_speed_q  <= cfg_data_i[11:0];
        mofsm_pkg::REG_SLOW_SPEED:     slow_speed_q  <= cfg_data_i[11:0];
        mofsm_pkg::REG_BLADE_SPEED:    blade_speed_q <= cfg_data_i[11:0];
        mofsm_pkg::REG_SLOW_DISTANCE:  slow_dist_q   <= cfg_data_i;
        mofsm_pkg::REG_TURN_DISTANCE:  turn_dist_q   <= cfg_data_i;
        mofsm_pkg::REG_CLOSE_DISTANCE: close_dist_q  <= cfg_data_i;
        mofsm_pkg::REG_REVERSE_TICKS:  rev_ticks_q   <= cfg_data_i[7:0];
        mofsm_pkg::REG_ROTATE_TICKS:   rot_ticks_q   <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  mofsm_deg u_deg (
    .mdeg_i (s1_mdeg_q),
    .deg_o  (s1_deg)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= s_axis_tvalid;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_hit_q  <= !s_axis_tdata[0] || !s_axis_tdata[1];
      s1_lift_q <= s_axis_tdata[2];
      s1_dist_q <= s_axis_tdata[18:3];
      s1_mdeg_q <= s_axis_tdata[37:19];
      s2_hit_q  <= s1_hit_q;
      s2_lift_q <= s1_lift_q;
      s2_dist_q <= s1_dist_q;
      s2_deg_q  <= s1_deg;
    end
  end

  always_comb begin
    logic [mofsm_pkg::DEG_W-1:0] diff;
    logic [1:0]                  halt_inc;
    logic [2:0]                  near_inc;

    mode_d      = mode_q;
    left_d      = left_q;
    right_d     = right_q;
    blade_d     = blade_q;
    ldir_d      = ldir_q;
    rdir_d      = rdir_q;
    rev_cnt_d   = rev_cnt_q;
    rot_cnt_d   = rot_cnt_q;
    halt_cnt_d  = halt_cnt_q;
    near_cnt_d  = near_cnt_q;
    bump_d      = bump_q;
    start_hdg_d = start_hdg_q;

    diff = (start_hdg_q > s2_deg_q) ? (start_hdg_q - s2_deg_q) : (s2_deg_q - start_hdg_q);
    if (diff > mofsm_pkg::HALF_TURN_DEG) begin
      diff = mofsm_pkg::DEG_W'(mofsm_pkg::FULL_TURN_DEG - mofsm_pkg::QDEG_W'(diff));
    end
    halt_inc = (halt_cnt_q < HALT_MAX) ? (halt_cnt_q + 2'd1) : halt_cnt_q;
    near_inc = near_cnt_q + 3'd1;

    case (mode_q)
      MODE_FWD: begin
        left_d  = fast_speed_q; ldir_d = 1'b1;
        right_d = fast_speed_q; rdir_d = 1'b0;
        blade_d = blade_speed_q;
        mode_d  = MODE_CHECK;
      end
      MODE_SLOW: begin
        left_d  = slow_speed_q; ldir_d = 1'b1;
        right_d = slow_speed_q; rdir_d = 1'b0;
        blade_d = blade_speed_q;
        mode_d  = MODE_CHECK;
      end
      MODE_BACK: begin
        left_d  = fast_speed_q; ldir_d = 1'b0;
        right_d = fast_speed_q; rdir_d = 1'b1;
        blade_d = blade_speed_q;
        if (rev_cnt_q < rev_ticks_q) begin
          rev_cnt_d = rev_cnt_q + 8'd1;
        end else begin
          rev_cnt_d = 8'd0;
          mode_d    = MODE_STARTROT;
        end
      end
      MODE_STARTROT: begin
        rot_cnt_d   = 8'd0;
        start_hdg_d = s2_deg_q;
        mode_d      = MODE_ROT;
      end
      MODE_ROT: begin
        left_d  = 12'd0;        ldir_d = 1'b1;
        right_d = slow_speed_q; rdir_d = 1'b0;
        blade_d = blade_speed_q;
        if (rot_cnt_q < rot_ticks_q && diff < mofsm_pkg::TURN_DEG) begin
          rot_cnt_d = rot_cnt_q + 8'd1;
        end else begin
          rot_cnt_d = 8'd0;
          mode_d    = MODE_CHECK;
        end
      end
      MODE_STOP: begin
        halt_cnt_d = halt_inc;
        if (halt_inc >= HALT_LIMIT) begin
          halt_cnt_d = 2'd0;
          mode_d     = bump_q ? MODE_BACK : MODE_CHECK;
        end
      end
      MODE_CHECK: begin
        if (!s2_lift_q) begin
          mode_d = MODE_ERROR;
        end else if (s2_hit_q) begin
          bump_d = 1'b1;
          mode_d = MODE_STOP;
        end else begin
          bump_d = 1'b0;
          if (s2_dist_q >= slow_dist_q) begin
            mode_d = MODE_FWD;
          end else if (s2_dist_q > turn_dist_q) begin
            mode_d = MODE_SLOW;
          end else if (s2_dist_q > close_dist_q) begin
            mode_d = MODE_STARTROT;
          end else if (near_inc > NEAR_LIMIT) begin
            near_cnt_d = 3'd0;
            mode_d     = MODE_BACK;
          end else begin
            near_cnt_d = near_inc;
            mode_d     = MODE_STOP;
          end
        end
      end
      MODE_ERROR: begin
        if (s2_lift_q) begin
          mode_d = MODE_CHECK;
        end
      end
      default: begin
        left_d  = 12'd0;
        right_d = 12'd0;
        blade_d = 12'd0;
        mode_d  = MODE_CHECK;
      end
    endcase

    off_d = (mode_d == MODE_STOP) || (mode_d == MODE_ERROR);
    if (off_d) begin
      left_d  = 12'd0;
      right_d = 12'd0;
      blade_d = 12'd0;
      ldir_d  = 1'b1;
      rdir_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_INIT;
      left_q      <= 12'd0;
      right_q     <= 12'd0;
      blade_q     <= 12'd0;
      ldir_q      <= 1'b0;
      rdir_q      <= 1'b0;
      rev_cnt_q   <= 8'd0;
      rot_cnt_q   <= 8'd0;
      halt_cnt_q  <= 2'd0;
      near_cnt_q  <= 3'd0;
      bump_q      <= 1'b0;
      start_hdg_q <= '0;
      off_q       <= 1'b0;
    end else if (adv && s2_valid_q) begin
      mode_q      <= mode_d;
      left_q      <= left_d;
      right_q     <= right_d;
      blade_q     <= blade_d;
      ldir_q      <= ldir_d;
      rdir_q      <= rdir_d;
      rev_cnt_q   <= rev_cnt_d;
      rot_cnt_q   <= rot_cnt_d;
      halt_cnt_q  <= halt_cnt_d;
      near_cnt_q  <= near_cnt_d;
      bump_q      <= bump_d;
      start_hdg_q <= start_hdg_d;
      off_q       <= off_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'd0, off_q, blade_q, rdir_q, right_q, ldir_q, left_q, mode_q};

  `MOFSM_ASSERT(a_off_speeds_zero, clk_i, rst_ni, off_q |-> ((left_q | right_q | blade_q) == 12'd0))
  `MOFSM_ASSERT(a_halt_bounded, clk_i, rst_ni, halt_cnt_q != HALT_MAX)
  `MOFSM_ASSERT(a_near_bounded, clk_i, rst_ni, near_cnt_q <= NEAR_LIMIT)
  `MOFSM_ASSERT(a_rot_cnt_idle, clk_i, rst_ni, (mode_q != MODE_ROT) |-> (rot_cnt_q == 8'd0))
  `MOFSM_ASSERT(a_rev_cnt_idle, clk_i, rst_ni, (mode_q != MODE_BACK) |-> (rev_cnt_q == 8'd0))

endmodule

`default_nettype wire

/* hdl/mofsm_deg.sv */
// ----------------------------------------------------------------------------
// Mower obstacle motion FSM - heading conversion
// Millidegrees to whole degrees folded into 0..359 (reciprocal multiply).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mofsm_deg (
  input  wire logic [mofsm_pkg::MDEG_W-1:0] mdeg_i,
  output logic      [mofsm_pkg::DEG_W-1:0]  deg_o
);

  logic [mofsm_pkg::PROD_W-1:0] prod;
  logic [mofsm_pkg::QDEG_W-1:0] quot;
  logic [mofsm_pkg::QDEG_W-1:0] fold;

  assign prod = mofsm_pkg::PROD_W'(mdeg_i) * mofsm_pkg::PROD_W'(mofsm_pkg::RECIP_1000);
  assign quot = prod[mofsm_pkg::RECIP_SHIFT +: mofsm_pkg::QDEG_W];
  assign fold = (quot >= mofsm_pkg::FULL_TURN_DEG) ? (quot - mofsm_pkg::FULL_TURN_DEG) : quot;
  assign deg_o = fold[mofsm_pkg::DEG_W-1:0];

endmodule

`default_nettype wire
